[rtl/sse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shamir share evaluation package
// Shared widths, constants and the request interface between control and the multiplier.
// ----------------------------------------------------------------------------
package sse_pkg;
    localparam int unsigned W_VAL = 31;
    localparam int unsigned W_CNT = 5;
    localparam int unsigned DEF_MAX_COEFS = 16;
    localparam logic [W_VAL-1:0] RESET_MODULUS = 31'd7;
    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_COEF_COUNT = 2'd1;
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef struct packed {
        logic start;
        logic [W_VAL-1:0] a;
        logic [W_VAL-1:0] b;
        logic [W_VAL-1:0] m;
    } t_mm_req;
endpackage
`default_nettype wire

[rtl/sse_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shamir share evaluation bit cell
// One step of a shift-and-add modular multiply: takes the partial result
// from its neighbor and one multiplier bit, hands on the reduced sum.
// ----------------------------------------------------------------------------
module sse_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [sse_pkg::W_VAL-1:0] i_acc,
    input  wire logic                      i_bit,
    input  wire logic [sse_pkg::W_VAL-1:0] i_a,
    input  wire logic [sse_pkg::W_VAL-1:0] i_m,
    output logic      [sse_pkg::W_VAL-1:0] o_acc
);
    import sse_pkg::*;
    logic [W_VAL-1:0] r_acc;
    logic [W_VAL:0] dbl;
    logic [W_VAL-1:0] d;
    logic [W_VAL:0] sum;
    logic [W_VAL-1:0] n_acc;

    always_comb begin
        dbl = {i_acc, 1'b0};
        d = (dbl >= {1'b0, i_m}) ? W_VAL'(dbl - {1'b0, i_m}) : dbl[W_VAL-1:0];
        sum = {1'b0, d} + (i_bit ? {1'b0, i_a} : '0);
        n_acc = (sum >= {1'b0, i_m}) ? W_VAL'(sum - {1'b0, i_m}) : sum[W_VAL-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end
    assign o_acc = r_acc;
endmodule
`default_nettype wire

[rtl/sse_mulmod.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shamir share evaluation modular multiplier
// A row of bit cells, one per multiplier bit, most significant first. One
// cell is enabled per cycle, down the row; the last cell gives the product.
// ----------------------------------------------------------------------------
module sse_mulmod (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire sse_pkg::t_mm_req          i_req,
    output logic                           o_done,
    output logic      [sse_pkg::W_VAL-1:0] o_prod
);
    import sse_pkg::*;
    logic [W_VAL-1:0] r_a, r_b, r_m;
    logic [W_VAL-1:0] r_en;
    logic r_done;
    logic [W_VAL-1:0] acc [W_VAL+1];

    assign acc[0] = '0;
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_m <= i_req.m;
        end
        if (!i_rst_n) begin
            r_en <= '0;
            r_done <= 1'b0;
        end else begin
            r_en <= {r_en[W_VAL-2:0], i_req.start};
            r_done <= r_en[W_VAL-1];
        end
    end

    for (genvar g = 0; g < W_VAL; g++) begin : g_cell
        sse_cell u_cell (
            .i_clk(i_clk),
            .i_en (r_en[g]),
            .i_acc(acc[g]),
            .i_bit(r_b[W_VAL-1-g]),
            .i_a  (r_a),
            .i_m  (r_m),
            .o_acc(acc[g+1])
        );
    end
    assign o_done = r_done;
    assign o_prod = acc[W_VAL];
endmodule
`default_nettype wire

[rtl/shamir_share_evaluation.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shamir share evaluation
// A load request writes one coefficient and leaves the block idle. An evaluate
// request reduces the point and the secret by a restoring divider and then runs
// Horner's rule on a chain of bit cells. Each coefficient takes a fetch, an add
// and a modular multiply. coef_count coefficients are used, saturated at
// MAX_COEFS; when the modulus is zero the share is zero and is offered without
// the divider or the multiply. One request is in work at a time; the input stays
// stalled until the share has been taken.
// ----------------------------------------------------------------------------
module shamir_share_evaluation #(
    parameter int unsigned MAX_COEFS = sse_pkg::DEF_MAX_COEFS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_kind,
    input  wire logic [3:0]                i_coef_index,
    input  wire logic [sse_pkg::W_VAL-1:0] i_coef_value,
    input  wire logic [sse_pkg::W_VAL-1:0] i_secret,
    input  wire logic [sse_pkg::W_VAL-1:0] i_point,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic      [sse_pkg::W_VAL-1:0] o_share,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready
);
    import sse_pkg::*;
    localparam int unsigned W_IDX = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam int unsigned W_N = $clog2(MAX_COEFS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RED   = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_ADD   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    logic [W_VAL-1:0] r_modulus;
    logic [W_CNT-1:0] r_coef_count;
    logic [W_VAL-1:0] mem [MAX_COEFS];
    logic [W_VAL-1:0] r_rd;
    t_state r_state;
    logic [W_VAL-1:0] r_m, r_x, r_s, r_acc, r_share;
    logic [W_N-1:0] r_j;
    logic r_ovalid;
    // Divider for reducing secret and point.
    logic [W_VAL-1:0] r_dq, r_dr;
    logic [5:0] r_dcnt;
    logic r_dsec;
    logic [W_VAL:0] dtr;
    logic [W_VAL-1:0] dred;
    logic [W_N-1:0] n_eff;
    logic [W_VAL:0] add_s;
    logic [W_VAL-1:0] add_r, rd_red;
    logic [W_VAL:0] fin_s;
    logic [W_VAL-1:0] fin_r;
    t_mm_req mm_req;
    logic mm_done;
    logic [W_VAL-1:0] mm_prod;
    logic in_acc, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr[2:2])
            REG_MODULUS[0]: prdata = {1'b0, r_modulus};
            default: prdata = {27'd0, r_coef_count};
        endcase
    end

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign in_acc = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_share = r_share;

    always_comb begin
        if (32'(r_coef_count) > MAX_COEFS) n_eff = W_N'(MAX_COEFS);
        else n_eff = W_N'(r_coef_count);
        dtr = {r_dr, r_dq[W_VAL-1]};
        dred = (dtr >= {1'b0, r_m}) ? W_VAL'(dtr - {1'b0, r_m}) : dtr[W_VAL-1:0];
        rd_red = (r_rd >= r_m) ? W_VAL'(r_rd - r_m) : r_rd;
        add_s = {1'b0, r_acc} + {1'b0, rd_red};
        add_r = (add_s >= {1'b0, r_m}) ? W_VAL'(add_s - {1'b0, r_m}) : add_s[W_VAL-1:0];
        fin_s = {1'b0, r_acc} + {1'b0, r_s};
        fin_r = (fin_s >= {1'b0, r_m}) ? W_VAL'(fin_s - {1'b0, r_m}) : fin_s[W_VAL-1:0];
        mm_req.start = (r_state == S_MUL);
        mm_req.a = r_x;
        mm_req.b = r_acc;
        mm_req.m = r_m;
    end

    sse_mulmod u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mm_req),
        .o_done(mm_done), .o_prod(mm_prod)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc && i_kind == KIND_LOAD && 32'(i_coef_index) < MAX_COEFS) begin
            mem[W_IDX'(i_coef_index)] <= i_coef_value;
        end
        r_rd <= mem[W_IDX'(r_j - W_N'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= RESET_MODULUS;
            r_coef_count <= '0;
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_MODULUS[0]) r_modulus <= pwdata[W_VAL-1:0];
            if (cfg_wr && paddr[2] == REG_COEF_COUNT[0]) r_coef_count <= pwdata[W_CNT-1:0];
            if (r_state == S_OUT) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_kind == KIND_EVAL) begin
                        r_m <= r_modulus;
                        r_s <= i_secret;
                        r_dq <= i_point;
                        r_dr <= '0;
                        r_dcnt <= '0;
                        r_dsec <= 1'b0;
                        r_j <= n_eff;
                        r_acc <= '0;
                        if (r_modulus == '0) begin
                            r_share <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (r_dcnt == 6'(W_VAL - 1)) begin
                        r_dcnt <= '0;
                        if (!r_dsec) begin
                            r_x <= dred;
                            r_dsec <= 1'b1;
                            r_dq <= r_s;
                            r_dr <= '0;
                        end else begin
                            r_s <= dred;
                            r_state <= S_FETCH;
                        end
                    end else begin
                        r_dq <= {r_dq[W_VAL-2:0], 1'b0};
                        r_dr <= dred;
                        r_dcnt <= r_dcnt + 6'd1;
                    end
                end
                S_FETCH: begin
                    if (r_j == '0) begin
                        r_share <= fin_r;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_acc <= add_r;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_WAIT;
                S_WAIT: begin
                    if (mm_done) begin
                        r_acc <= mm_prod;
                        r_j <= r_j - W_N'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shamir share evaluation testbench
// Loads coefficient tables, evaluates shares at directed and random points
// and checks every share against a Horner-rule predictor. Walks several
// modulus and coefficient-count settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
    import sse_pkg::*;

    localparam int HOLD_CYCLES = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_kind = KIND_LOAD;
    logic [3:0] i_coef_index = '0;
    logic [W_VAL-1:0] i_coef_value = '0;
    logic [W_VAL-1:0] i_secret = '0;
    logic [W_VAL-1:0] i_point = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    logic [W_VAL-1:0] o_share;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    shamir_share_evaluation dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [W_VAL-1:0] fld_modulus = RESET_MODULUS;
    logic [W_CNT-1:0] fld_count = '0;
    logic [W_VAL-1:0] coef_table [16];
    logic [W_VAL-1:0] share_queue [$];
    int errors = 0;
    bit hold_req = 0;

    function automatic logic [W_VAL-1:0] share_of(input logic [W_VAL-1:0] secret,
                                                  input logic [W_VAL-1:0] point);
        logic [63:0] m, x, acc;
        int n;
        m = fld_modulus;
        if (m == 0) return '0;
        n = (fld_count > 16) ? 16 : fld_count;
        x = point % m;
        acc = 0;
        for (int j = n; j > 0; j--) begin
            acc = (acc + coef_table[j-1] % m) % m;
            acc = (acc * x) % m;
        end
        acc = (acc + secret % m) % m;
        return acc[W_VAL-1:0];
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx[0], 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_MODULUS) fld_modulus = value[W_VAL-1:0];
        else fld_count = value[W_CNT-1:0];
    endtask

    task automatic send(input logic kind, input logic [3:0] idx,
                        input logic [W_VAL-1:0] value, input logic [W_VAL-1:0] secret,
                        input logic [W_VAL-1:0] point, input bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1; i_kind <= kind; i_coef_index <= idx;
        i_coef_value <= value; i_secret <= secret; i_point <= point;
        do @(posedge i_clk); while (o_stall);
        if (kind == KIND_LOAD) begin
            coef_table[idx] = value;
        end else begin
            share_queue = {share_queue, share_of(secret, point)};
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (share_queue.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
    endtask

    task automatic load_all(input logic [W_VAL-1:0] limit);
        for (int i = 0; i < 16; i++)
            send(KIND_LOAD, i[3:0], W_VAL'($urandom_range(0, limit)), '0, '0);
    endtask

    function automatic logic [W_VAL-1:0] rnd31();
        return W_VAL'($urandom);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (share_queue.size() == 0) begin
                $error("unexpected share %0d", o_share);
                errors++;
            end else begin
                logic [W_VAL-1:0] exp_share;
                exp_share = share_queue.pop_front();
                if (o_share !== exp_share) begin
                    $error("share: expected %0d actual %0d", exp_share, o_share);
                    errors++;
                end
            end
        end
    end

    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                if (w != 0) begin
                    i_stall <= 1'b1;
                    repeat (w) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                do @(posedge i_clk); while (!o_valid && !hold_req);
            end
        end
    end

    task automatic test_reset_modulus();
        load_all(W_VAL'(32'h7FFF_FFFE));
        send(KIND_EVAL, '0, '0, '1, '1);
        send(KIND_EVAL, '0, '0, '0, '0);
        drain();
    endtask

    task automatic test_directed();
        write_reg(REG_MODULUS, 32'h7FFF_FFFF);
        write_reg(REG_COEF_COUNT, 32'd16);
        send(KIND_LOAD, 4'd0, W_VAL'(32'h7FFF_FFFE), '0, '0);
        send(KIND_LOAD, 4'd15, '0, '0, '0);
        send(KIND_EVAL, '0, '0, '1, '1);
        send(KIND_EVAL, '0, '0, '0, '0);
        send(KIND_EVAL, '0, '0, W_VAL'(32'h7FFF_FFFE), W_VAL'(32'h7FFF_FFFE));
        send(KIND_EVAL, '0, '0, W_VAL'(32'h5555_5555), W_VAL'(32'h2AAA_AAAA));
        drain();
        write_reg(REG_COEF_COUNT, 32'd31);
        send(KIND_EVAL, '0, '0, W_VAL'(12345), W_VAL'(3));
        drain();
        write_reg(REG_MODULUS, 32'd0);
        send(KIND_EVAL, '0, '0, '1, '1);
        drain();
        write_reg(REG_MODULUS, 32'd1);
        send(KIND_EVAL, '0, '0, '1, '1);
        drain();
        write_reg(REG_MODULUS, 32'd2);
        write_reg(REG_COEF_COUNT, 32'd0);
        send(KIND_EVAL, '0, '0, '1, '1);
        drain();
    endtask

    task automatic test_random_phases();
        logic [31:0] mods [5] = '{32'h7FFF_FFFF, 32'd2, 32'd65521, 32'd1000003, 32'd0};
        for (int p = 0; p < 5; p++) begin
            write_reg(REG_MODULUS, mods[p]);
            write_reg(REG_COEF_COUNT, 32'($urandom_range(0, 16)));
            for (int i = 0; i < 222; i++) begin
                if ($urandom_range(0, 2) == 0)
                    send(KIND_LOAD, 4'($urandom_range(0, 15)), rnd31(), '0, '0);
                else
                    send(KIND_EVAL, 4'($urandom), rnd31(), rnd31(), rnd31());
                if (i % 70 == 69) begin
                    drain();
                    write_reg(REG_COEF_COUNT, 32'($urandom_range(0, 31)));
                end
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_MODULUS, 32'd2147483629);
        write_reg(REG_COEF_COUNT, 32'd2);
        hold_req = 1;
        for (int i = 0; i < 8; i++)
            send(KIND_EVAL, '0, '0, rnd31(), rnd31(), 0);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_modulus();
        test_directed();
        test_backpressure();
        test_random_phases();
        if (errors == 0 && share_queue.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
